>>> sv/allpass_phaser_effect_core_macros.svh
// ============================================================================
// Assertion macros for the allpass phaser
// Shared concurrent assertion forms used by the top level.
// ============================================================================
`ifndef ALLPASS_PHASER_EFFECT_CORE_MACROS_SVH
`define ALLPASS_PHASER_EFFECT_CORE_MACROS_SVH

// Implication checked on the next edge after the antecedent.
`define APH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked in the same cycle.
`define APH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/aph_pkg.sv
// ============================================================================
// Allpass phaser package
// Widths, register indexes, reset values, sine coefficients and the cell control type.
// ============================================================================
package aph_pkg;

    localparam int NUM_STAGES_DEF   = 6;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LFO_INC   = 3'd0,
        REG_SWEEP_MIN = 3'd1,
        REG_SWEEP_MAX = 3'd2,
        REG_FB_GAIN   = 3'd3,
        REG_MIX_DEPTH = 3'd4
    } reg_idx_t;

    localparam logic [30:0] LFO_INC_RST   = 31'd48697;
    localparam logic [15:0] SWEEP_MIN_RST = 16'd1308;
    localparam logic [15:0] SWEEP_MAX_RST = 16'd4755;
    localparam logic [15:0] FB_GAIN_RST   = 16'd45875;
    localparam logic [16:0] MIX_DEPTH_RST = 17'd65536;

    localparam logic [16:0] SIN_C1 = 17'd51472;
    localparam logic [16:0] SIN_C3 = 17'd21024;
    localparam logic [16:0] SIN_C5 = 17'd2320;

    // Control handed along the row of stage cells.
    typedef struct packed {
        logic       start;
        logic [16:0] coef;
    } cell_ctl_t;

endpackage

>>> sv/aph_stream_if.sv
// ============================================================================
// Valid/ready stream interface
// One beat carries one signed sample.
// ============================================================================
interface aph_stream_if #(
    parameter int WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/aph_cell.sv
// ============================================================================
// Allpass stage cell
// One first-order allpass section; it fires when its neighbor hands it x.
// ============================================================================
module aph_cell #(
    parameter int STATE_W = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr,
    input  aph_pkg::cell_ctl_t        ctl_in,
    input  logic signed [STATE_W-1:0] x_in,
    output logic                      done,
    output logic signed [STATE_W-1:0] y_out
);
    localparam logic signed [STATE_W-1:0] HI = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] LO = {1'b1, {(STATE_W-1){1'b0}}};

    typedef enum logic [1:0] { S_IDLE, S_Y, S_Z } cstate_t;

    cstate_t                   st_reg;
    logic signed [STATE_W-1:0] z_reg, x_reg, y_reg;
    logic [16:0]               a_reg;
    logic                      done_reg;

    logic signed [STATE_W+18:0] prod;
    logic signed [STATE_W+2:0]  rnd, sum;
    logic signed [STATE_W-1:0]  mop, satv;

    always_comb
    begin
        mop  = (st_reg == S_Y) ? x_reg : y_reg;
        prod = $signed({{19{mop[STATE_W-1]}}, mop}) *
               $signed({{(STATE_W+2){1'b0}}, a_reg});
        rnd  = (STATE_W+3)'((prod + (STATE_W+19)'(32768)) >>> 16);
        if (st_reg == S_Y)
            sum = (STATE_W+3)'(z_reg) - rnd;
        else
            sum = rnd + (STATE_W+3)'(x_reg);
        if (sum > (STATE_W+3)'(HI))
            satv = HI;
        else if (sum < (STATE_W+3)'(LO))
            satv = LO;
        else
            satv = sum[STATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (ctl_in.start)
                    begin
                        x_reg  <= x_in;
                        a_reg  <= ctl_in.coef;
                        st_reg <= S_Y;
                    end
                end
                S_Y:
                begin
                    y_reg  <= satv;
                    st_reg <= S_Z;
                end
                S_Z:
                begin
                    z_reg    <= satv;
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
            if (clr)
                z_reg <= '0;
        end
    end

    assign done  = done_reg;
    assign y_out = y_reg;
endmodule

>>> sv/aph_coef.sv
// ============================================================================
// Coefficient unit
// Sine LFO, sweep interpolation and a bit-serial divider for a=(1-d)/(1+d).
// ============================================================================
module aph_coef (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] phase,
    input  logic [15:0] sweep_min,
    input  logic [15:0] sweep_max,
    output logic        done,
    output logic [16:0] coef
);
    typedef enum logic [2:0] { C_IDLE, C_T2, C_IN, C_MID, C_MAG, C_D, C_DIV } cstate_t;

    localparam logic [16:0] SIN_C5_L = aph_pkg::SIN_C5;

    cstate_t     st_reg;
    logic [15:0] t_reg;
    logic [16:0] t2_reg, w_reg;
    logic [16:0] u_reg;
    logic [16:0] d_reg;
    logic        hi_half_reg;
    logic [34:0] rem_reg;
    logic [17:0] den_reg;
    logic [16:0] q_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;

    logic [30:0] fx;
    logic [33:0] p;
    logic [17:0] mag;
    logic [33:0] dsum;

    always_comb
    begin
        // The folded quarter phase reaches a full quarter turn, so it keeps bit 30.
        fx    = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        p     = '0;
        mag   = '0;
        dsum  = '0;
        unique case (st_reg)
            C_T2:  p = 34'(t_reg) * 34'(t_reg);
            C_IN:  p = 34'(t2_reg) * 34'(SIN_C5_L);
            C_MID: p = 34'(t2_reg) * 34'(w_reg);
            C_MAG: p = 34'(t_reg) * 34'(w_reg);
            default: p = '0;
        endcase
        mag  = 18'(p >> 15);
        dsum = 34'(sweep_min) * 34'(17'h10000 - u_reg) + 34'(sweep_max) * 34'(u_reg)
             + 34'd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        t_reg       <= fx[30:15];
                        hi_half_reg <= phase[31];
                        st_reg      <= C_T2;
                    end
                end
                C_T2:
                begin
                    t2_reg <= 17'(p >> 15);
                    st_reg <= C_IN;
                end
                C_IN:
                begin
                    w_reg  <= aph_pkg::SIN_C3 - 17'(p >> 15);
                    st_reg <= C_MID;
                end
                C_MID:
                begin
                    w_reg  <= aph_pkg::SIN_C1 - 17'(p >> 15);
                    st_reg <= C_MAG;
                end
                C_MAG:
                begin
                    if (mag > 18'd32768)
                        u_reg <= hi_half_reg ? 17'd0 : 17'd65536;
                    else
                        u_reg <= hi_half_reg ? 17'(18'd32768 - mag) : 17'(18'd32768 + mag);
                    st_reg <= C_D;
                end
                C_D:
                begin
                    d_reg   <= 17'(dsum >> 16);
                    st_reg  <= C_DIV;
                    cnt_reg <= '0;
                end
                C_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        // Numerator (1-d)*2^16 plus half the divisor, for rounding.
                        rem_reg <= 35'((35'(17'h10000 - d_reg) << 16)
                                 + 35'((18'h10000 + 18'(d_reg)) >> 1));
                        den_reg <= 18'h10000 + 18'(d_reg);
                        q_reg   <= '0;
                        cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        // Restoring long division, one quotient bit a cycle.
                        if (rem_reg[34:17] >= den_reg)
                        begin
                            rem_reg <= 35'(({rem_reg[34:17] - den_reg, rem_reg[16:0]}) << 1);
                            q_reg   <= {q_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_reg << 1;
                            q_reg   <= {q_reg[15:0], 1'b0};
                        end
                        if (cnt_reg == 6'd18)
                        begin
                            st_reg   <= C_IDLE;
                            done_reg <= 1'b1;
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                default: st_reg <= C_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign coef = q_reg;
endmodule

>>> sv/allpass_phaser_effect_core.sv
// ============================================================================
// Six-stage allpass phaser core
// Sine-swept first-order allpass chain with feedback and wet/dry mix.
// ============================================================================
// One sample is processed at a time. An accepted beat first runs the
// coefficient unit (five sine/sweep multiply steps and a bit-serial divider
// for the shared allpass coefficient), then the feedback multiply, then
// travels down the row of NUM_STAGES stage cells, and finally the wet/dry
// mix and saturation. The result sits in an output register, and the next
// beat is taken as soon as the chain is free, even while that result still
// waits for the sink. Configuration is written through a plain write port,
// register i at index i; unknown indexes are ignored and mix_depth above
// one acts as one.
module allpass_phaser_effect_core #(
    parameter int NUM_STAGES   = aph_pkg::NUM_STAGES_DEF,
    parameter int SAMPLE_WIDTH = aph_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    aph_stream_if.sink                       in_stream,
    aph_stream_if.source                     out_stream,
    input  logic                             cfg_we,
    input  logic [aph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aph_pkg::CFG_DATA_W-1:0]   cfg_data
);
    `include "allpass_phaser_effect_core_macros.svh"

    localparam int SW = SAMPLE_WIDTH;
    localparam int STW = SAMPLE_WIDTH + 8;
    localparam logic signed [STW-1:0] SHI = {1'b0, {(STW-1){1'b1}}};
    localparam logic signed [STW-1:0] SLO = {1'b1, {(STW-1){1'b0}}};
    localparam logic signed [SW-1:0]  OHI = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]  OLO = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [2:0] { P_IDLE, P_COEF, P_FB, P_CHAIN, P_MIX, P_OUT } pstate_t;

    // Configuration registers.
    logic [30:0] lfo_inc_reg;
    logic [15:0] sweep_min_reg, sweep_max_reg, fb_gain_reg;
    logic [16:0] mix_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_inc_reg   <= aph_pkg::LFO_INC_RST;
            sweep_min_reg <= aph_pkg::SWEEP_MIN_RST;
            sweep_max_reg <= aph_pkg::SWEEP_MAX_RST;
            fb_gain_reg   <= aph_pkg::FB_GAIN_RST;
            mix_depth_reg <= aph_pkg::MIX_DEPTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aph_pkg::REG_LFO_INC:   lfo_inc_reg   <= cfg_data[30:0];
                aph_pkg::REG_SWEEP_MIN: sweep_min_reg <= cfg_data[15:0];
                aph_pkg::REG_SWEEP_MAX: sweep_max_reg <= cfg_data[15:0];
                aph_pkg::REG_FB_GAIN:   fb_gain_reg   <= cfg_data[15:0];
                aph_pkg::REG_MIX_DEPTH: mix_depth_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    pstate_t                st_reg;
    logic [31:0]            phase_reg;
    logic signed [SW-1:0]   s_reg;
    logic signed [STW-1:0]  last_reg;
    logic signed [STW-1:0]  x_reg;
    logic                   coef_go_reg;
    logic                   chain_go_reg;
    logic                   ovalid_reg;
    logic signed [SW-1:0]   odata_reg;
    logic                   coef_done;
    logic [16:0]            coef;

    aph_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (coef_go_reg),
        .phase     (phase_reg),
        .sweep_min (sweep_min_reg),
        .sweep_max (sweep_max_reg),
        .done      (coef_done),
        .coef      (coef)
    );

    // Row of stage cells; each hands its y to the next one with a start pulse.
    aph_pkg::cell_ctl_t       ctl   [NUM_STAGES];
    logic signed [STW-1:0]    xin   [NUM_STAGES];
    logic signed [STW-1:0]    yout  [NUM_STAGES];
    logic                     cdone [NUM_STAGES];
    logic [16:0]              a_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign ctl[g].start = chain_go_reg;
                assign xin[g]       = x_reg;
            end
            else
            begin : g_next
                assign ctl[g].start = cdone[g-1];
                assign xin[g]       = yout[g-1];
            end
            assign ctl[g].coef = a_reg;
            aph_cell #(.STATE_W(STW)) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .clr    (1'b0),
                .ctl_in (ctl[g]),
                .x_in   (xin[g]),
                .done   (cdone[g]),
                .y_out  (yout[g])
            );
        end
    endgenerate

    logic signed [STW-1:0] y_last;
    assign y_last = yout[NUM_STAGES-1];

    // Shared multiply-round for feedback and mix.
    logic signed [STW-1:0]    m_op;
    logic [16:0]              m_g;
    logic signed [STW+18:0]   m_prod;
    logic signed [STW+2:0]    m_rnd;
    logic signed [STW+2:0]    fb_sum;
    logic signed [STW+2:0]    mix_sum;

    always_comb
    begin
        m_op = (st_reg == P_FB) ? last_reg : y_last;
        m_g  = (st_reg == P_FB) ? {1'b0, fb_gain_reg}
             : ((mix_depth_reg > 17'd65536) ? 17'd65536 : mix_depth_reg);
        m_prod = $signed({{19{m_op[STW-1]}}, m_op}) * $signed({{(STW+2){1'b0}}, m_g});
        m_rnd  = (STW+3)'((m_prod + (STW+19)'(32768)) >>> 16);
        fb_sum  = m_rnd + (STW+3)'(s_reg);
        mix_sum = m_rnd + (STW+3)'(s_reg);
    end

    assign in_stream.ready = (st_reg == P_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= P_IDLE;
            phase_reg    <= '0;
            last_reg     <= '0;
            coef_go_reg  <= 1'b0;
            chain_go_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            coef_go_reg  <= 1'b0;
            chain_go_reg <= 1'b0;
            if (out_stream.valid && out_stream.ready)
                ovalid_reg <= 1'b0;
            unique case (st_reg)
                P_IDLE:
                begin
                    if (in_stream.valid)
                    begin
                        s_reg       <= in_stream.data;
                        coef_go_reg <= 1'b1;
                        st_reg      <= P_COEF;
                    end
                end
                P_COEF:
                begin
                    if (coef_done)
                    begin
                        a_reg     <= coef;
                        phase_reg <= phase_reg + {1'b0, lfo_inc_reg};
                        st_reg    <= P_FB;
                    end
                end
                P_FB:
                begin
                    if (fb_sum > (STW+3)'(SHI))
                        x_reg <= SHI;
                    else if (fb_sum < (STW+3)'(SLO))
                        x_reg <= SLO;
                    else
                        x_reg <= fb_sum[STW-1:0];
                    chain_go_reg <= 1'b1;
                    st_reg       <= P_CHAIN;
                end
                P_CHAIN:
                begin
                    if (cdone[NUM_STAGES-1])
                    begin
                        last_reg <= y_last;
                        st_reg   <= P_MIX;
                    end
                end
                P_MIX:
                begin
                    // Wait for the output register to be free.
                    if (!ovalid_reg || out_stream.ready)
                    begin
                        if (mix_sum > (STW+3)'(OHI))
                            odata_reg <= OHI;
                        else if (mix_sum < (STW+3)'(OLO))
                            odata_reg <= OLO;
                        else
                            odata_reg <= mix_sum[SW-1:0];
                        ovalid_reg <= 1'b1;
                        st_reg     <= P_IDLE;
                    end
                end
                default: st_reg <= P_IDLE;
            endcase
        end
    end

    assign out_stream.valid = ovalid_reg;
    assign out_stream.data  = odata_reg;

    `APH_ASSERT_NEXT(a_accept_starts_coef, clk, rst_n,
        in_stream.valid && in_stream.ready, coef_go_reg)
    `APH_ASSERT_SAME(a_no_accept_busy, clk, rst_n,
        st_reg != P_IDLE, !in_stream.ready)
    `APH_ASSERT_NEXT(a_out_holds, clk, rst_n,
        out_stream.valid && !out_stream.ready, out_stream.valid && $stable(out_stream.data))
endmodule

>>> bench/allpass_phaser_effect_core_tb.sv
// ============================================================================
// Allpass phaser core testbench
// Samples are streamed through the phaser under several register settings.
// Each output beat is checked against a bit-exact predictor of the LFO, the
// coefficient, the six-stage allpass chain with feedback and the wet/dry mix.
// ============================================================================
module allpass_phaser_effect_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STAGES      = aph_pkg::NUM_STAGES_DEF;
    localparam int  SW          = aph_pkg::SAMPLE_WIDTH_DEF;
    localparam int  CHAIN_W     = SW + 8;
    localparam int  IDX_W       = aph_pkg::CFG_IDX_W;
    localparam int  DATA_W      = aph_pkg::CFG_DATA_W;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  HOLD_CYCLES = 400;
    localparam int  PHASES      = 8;
    localparam int  PHASE_ITEMS = 50;
    localparam int  FIRST_SPARE = aph_pkg::REG_MIX_DEPTH + 1;
    localparam longint UNITY    = 65536;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    aph_stream_if #(.WIDTH(SW)) in_if ();
    aph_stream_if #(.WIDTH(SW)) out_if ();

    allpass_phaser_effect_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Shadow copy of the registers and the filter state.
    logic [30:0] lfo_step;
    logic [15:0] sweep_lo;
    logic [15:0] sweep_hi;
    logic [15:0] fb_gain;
    logic [16:0] wet_gain;
    logic [31:0] lfo_phase;
    longint      stage_z [STAGES];
    longint      chain_last;

    logic signed [SW-1:0] expected_samples [$];
    int  mismatches;
    int  beats_checked;
    int  cfg_writes;
    bit  steady;          // When set, neither side idles.
    bit  hold_toggle;     // Each flip asks the sink for one long hold-off.

    function automatic longint clip(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Q1.16 gain, rounded to nearest with ties toward plus infinity.
    function automatic longint gain_q16(input longint v, input longint g);
        return (v * g + 32768) >>> 16;
    endfunction

    // Polynomial sine of the phase, mapped to 0..65536.
    function automatic longint lfo_level(input logic [31:0] ph);
        longint x;
        longint t;
        longint t2;
        longint inner;
        longint mid;
        longint mag;
        x = ph[29:0];
        if (ph[30])
            x = (longint'(1) << 30) - x;
        t = x >> 15;
        t2 = (t * t) >> 15;
        inner = aph_pkg::SIN_C3 - ((t2 * aph_pkg::SIN_C5) >> 15);
        mid = aph_pkg::SIN_C1 - ((t2 * inner) >> 15);
        mag = (t * mid) >> 15;
        if (mag > 32768)
            mag = 32768;
        return ph[31] ? 32768 - mag : 32768 + mag;
    endfunction

    function automatic logic signed [SW-1:0] phase_sample(input logic signed [SW-1:0] s);
        longint u;
        longint d;
        longint a;
        longint x;
        longint y;
        longint depth;
        u = lfo_level(lfo_phase);
        lfo_phase = lfo_phase + {1'b0, lfo_step};
        d = (longint'(sweep_lo) * (UNITY - u) + longint'(sweep_hi) * u + 32768) >> 16;
        a = ((UNITY - d) * UNITY + ((UNITY + d) >> 1)) / (UNITY + d);
        x = clip(longint'(s) + gain_q16(chain_last, fb_gain), CHAIN_W);
        y = x;
        for (int i = 0; i < STAGES; i++)
        begin
            y = clip(stage_z[i] - gain_q16(x, a), CHAIN_W);
            stage_z[i] = clip(gain_q16(y, a) + x, CHAIN_W);
            x = y;
        end
        chain_last = y;
        depth = (wet_gain > UNITY) ? UNITY : longint'(wet_gain);
        return SW'(clip(longint'(s) + gain_q16(y, depth), SW));
    endfunction

    task automatic report(input string what, input logic signed [SW-1:0] got,
                          input logic signed [SW-1:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Registers may only change while the chain is empty, so the shadow copy
    // is updated at the same edge as the write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            aph_pkg::REG_LFO_INC:   lfo_step = val[30:0];
            aph_pkg::REG_SWEEP_MIN: sweep_lo = val[15:0];
            aph_pkg::REG_SWEEP_MAX: sweep_hi = val[15:0];
            aph_pkg::REG_FB_GAIN:   fb_gain  = val[15:0];
            aph_pkg::REG_MIX_DEPTH: wet_gain = val[16:0];
            default: ;
        endcase
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [30:0] inc, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [15:0] fb,
                             input logic [16:0] mix);
        write_reg(aph_pkg::REG_LFO_INC, inc);
        write_reg(aph_pkg::REG_SWEEP_MIN, {15'd0, lo});
        write_reg(aph_pkg::REG_SWEEP_MAX, {15'd0, hi});
        write_reg(aph_pkg::REG_FB_GAIN, {15'd0, fb});
        write_reg(aph_pkg::REG_MIX_DEPTH, {14'd0, mix});
    endtask

    // Offers one beat, with an occasional gap before it, and books the
    // expected output once the beat is taken. Valid stays up afterwards so
    // back-to-back beats need no second assignment in one step.
    task automatic send_sample(input logic signed [SW-1:0] s);
        if (!steady && $urandom_range(99) < 9)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= s;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        expected_samples.push_back(phase_sample(s));
    endtask

    // Waits until every booked output has come back, then a little longer.
    task automatic drain;
        in_if.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] random_sample;
        if ($urandom_range(9) < 7)
            return SW'($urandom());
        return SW'($urandom_range(2000)) - SW'(1000);
    endfunction

    // Full-scale edges and bit patterns at the reset settings.
    task automatic test_reset_settings;
        logic signed [SW-1:0] pats [7];
        pats = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001,
                 16'sh5555, 16'shAAAA};
        foreach (pats[i])
            send_sample(pats[i]);
        drain();
    endtask

    // The fastest LFO, the widest sweep, maximum feedback and a depth above
    // one, fed with a full-scale square wave so that the chain and the output
    // both hit their saturation limits.
    task automatic test_saturation;
        write_all(31'h7FFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? -16'sh8000 : 16'sh7FFF);
        drain();
    endtask

    // A frozen LFO with the sweep running downward, no feedback, no wet part;
    // then writes to unused indexes, which must leave everything as it was.
    task automatic test_inverted_sweep_and_spares;
        write_all(31'd0, 16'hFFFF, 16'd0, 16'd0, 17'd0);
        for (int i = 0; i < 5; i++)
            send_sample(random_sample());
        drain();
        write_reg(aph_pkg::REG_MIX_DEPTH, 31'd65536);
        for (int i = FIRST_SPARE; i < (1 << IDX_W); i++)
            write_reg(IDX_W'(i), 31'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_sample(random_sample());
        drain();
    endtask

    // Random settings per phase, one phase without idling and one with the
    // sink held off for a long stretch while samples keep coming.
    task automatic test_random_stream;
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(aph_pkg::REG_LFO_INC, ($urandom_range(3) == 0) ? DATA_W'($urandom())
                                   : DATA_W'($urandom_range(2000000)));
            write_reg(aph_pkg::REG_SWEEP_MIN, DATA_W'($urandom()));
            write_reg(aph_pkg::REG_SWEEP_MAX, DATA_W'($urandom()));
            write_reg(aph_pkg::REG_FB_GAIN, DATA_W'($urandom()));
            write_reg(aph_pkg::REG_MIX_DEPTH, DATA_W'($urandom_range(131071)));
            steady = (p == 2);
            if (p == 5)
                hold_toggle <= ~hold_toggle;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(random_sample());
            drain();
        end
        steady = 1'b0;
    endtask

    // The sink stalls at random, or for one long stretch when asked.
    int hold_left;
    bit hold_seen;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            hold_left = 0;
            hold_seen = 1'b0;
        end
        else
        begin
            if (hold_seen != hold_toggle)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    // Every output beat is compared with the oldest booked sample.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_samples.size() == 0)
                report("unexpected beat", out_if.data, '0);
            else
            begin
                logic signed [SW-1:0] want;
                want = expected_samples.pop_front();
                beats_checked++;
                if (out_if.data !== want)
                    report("sample_out", out_if.data, want);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        hold_toggle <= 1'b0;
        steady      = 1'b0;
        mismatches  = 0;
        beats_checked = 0;
        cfg_writes  = 0;
        lfo_step    = aph_pkg::LFO_INC_RST;
        sweep_lo    = aph_pkg::SWEEP_MIN_RST;
        sweep_hi    = aph_pkg::SWEEP_MAX_RST;
        fb_gain     = aph_pkg::FB_GAIN_RST;
        wet_gain    = aph_pkg::MIX_DEPTH_RST;
        lfo_phase   = '0;
        chain_last  = 0;
        foreach (stage_z[i])
            stage_z[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_saturation();
        test_inverted_sweep_and_spares();
        test_random_stream();

        if (expected_samples.size() != 0)
            report("missing beat", '0, expected_samples[0]);
        $display("Checked %0d output beats over %0d register writes, including saturation,",
                 beats_checked, cfg_writes);
        $display("inverted sweep, spare indexes, excess depth and a long sink hold-off.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
